FILE: hdl/yfi_pkg.sv
package yfi_pkg;

    // default sizes of the plane stores
    localparam int MAX_ROW_DEF    = 64;
    localparam int MAX_COLS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    // fixed field widths
    localparam int FIELD_W    = 32;
    localparam int COMP_W     = 3;
    localparam int GXY_W      = 6;
    localparam int GZ_W       = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int NUM_COMP   = 6;
    localparam int NUM_TAPS   = 4;

    // component codes
    localparam logic [COMP_W-1:0] COMP_EX = 3'd0;
    localparam logic [COMP_W-1:0] COMP_EY = 3'd1;
    localparam logic [COMP_W-1:0] COMP_EZ = 3'd2;
    localparam logic [COMP_W-1:0] COMP_BX = 3'd3;
    localparam logic [COMP_W-1:0] COMP_BY = 3'd4;
    localparam logic [COMP_W-1:0] COMP_BZ = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = 2'd2;

    // stencil point codes: {z, y, x}, a set bit takes the current coordinate
    localparam logic [2:0] PT_0  = 3'b000;
    localparam logic [2:0] PT_X  = 3'b001;
    localparam logic [2:0] PT_Y  = 3'b010;
    localparam logic [2:0] PT_Z  = 3'b100;
    localparam logic [2:0] PT_YZ = 3'b110;
    localparam logic [2:0] PT_ZX = 3'b101;
    localparam logic [2:0] PT_XY = 3'b011;

    // point read by a component at a given read step
    function automatic logic [2:0] point_sel(input logic [COMP_W-1:0] comp,
                                             input logic [1:0] step);
        logic [2:0] p;
        p = PT_0;
        case (comp)
            COMP_EX: begin
                case (step)
                    2'd1:    p = PT_Y;
                    2'd2:    p = PT_Z;
                    2'd3:    p = PT_YZ;
                    default: p = PT_0;
                endcase
            end
            COMP_EY: begin
                case (step)
                    2'd1:    p = PT_Z;
                    2'd2:    p = PT_X;
                    2'd3:    p = PT_ZX;
                    default: p = PT_0;
                endcase
            end
            COMP_EZ: begin
                case (step)
                    2'd1:    p = PT_X;
                    2'd2:    p = PT_Y;
                    2'd3:    p = PT_XY;
                    default: p = PT_0;
                endcase
            end
            COMP_BX: p = (step == 2'd1) ? PT_X : PT_0;
            COMP_BY: p = (step == 2'd1) ? PT_Y : PT_0;
            COMP_BZ: p = (step == 2'd1) ? PT_Z : PT_0;
            default: p = PT_0;
        endcase
        return p;
    endfunction

endpackage

FILE: hdl/yfi_if.sv
interface yfi_in_if import yfi_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  e_x;
    logic signed [FIELD_W-1:0]  e_y;
    logic signed [FIELD_W-1:0]  e_z;
    logic signed [FIELD_W-1:0]  b_x;
    logic signed [FIELD_W-1:0]  b_y;
    logic signed [FIELD_W-1:0]  b_z;

    modport source (output valid, e_x, e_y, e_z, b_x, b_y, b_z, input ready);
    modport sink   (input valid, e_x, e_y, e_z, b_x, b_y, b_z, output ready);
endinterface

interface yfi_out_if import yfi_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [COMP_W-1:0]          component;
    logic signed [FIELD_W-1:0]  mean_value;
    logic signed [FIELD_W-1:0]  slope_first;
    logic signed [FIELD_W-1:0]  slope_second;
    logic signed [FIELD_W-1:0]  cross_term;
    logic [GXY_W-1:0]           voxel_x;
    logic [GXY_W-1:0]           voxel_y;
    logic [GZ_W-1:0]            voxel_z;
    logic                       last;

    modport source (output valid, component, mean_value, slope_first, slope_second,
                    cross_term, voxel_x, voxel_y, voxel_z, last, input ready);
    modport sink   (input valid, component, mean_value, slope_first, slope_second,
                    cross_term, voxel_x, voxel_y, voxel_z, last, output ready);
endinterface

interface yfi_cfg_if import yfi_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [CFG_DATA_W-1:0]  wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: hdl/yfi_field_ram.sv
module yfi_field_ram #(
    parameter int DW    = 32,
    parameter int DEPTH = 8192,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/yee_field_interpolator_stencil_top.sv
// Staggered-mesh interpolator stencil.
// Channels: i_in takes one field voxel per transfer (e_x .. b_z, Q16.16) in
// raster order, x fastest, over the grid 1..grid+1 on each axis. o_out gives
// six result transfers per interior voxel, components ex, ey, ez, bx, by, bz,
// with last set on bz. i_cfg writes grid_x, grid_y, grid_z (index 0, 1, 2);
// writing one restarts the scan at (1,1,1); unknown indexes are ignored.
// A voxel whose stencil is complete is written to the plane stores, then the
// stencil points are read back, one point per store a cycle (one read port
// per store), captured, moved to the result buffer and registered at the
// output. Voxels on the low faces are stored only and do not hold the input.
// The six result transfers per voxel share the single output channel; a
// capture buffer lets the next voxel's reads overlap the current output.
// Reset: scan and grid return to 1, all buffers empty; the stores are not
// cleared (every point is written before it is read).
// Output stall: the output register holds; i_in.ready is low from the
// transfer of a complete voxel until its points move to the result buffer.
module yee_field_interpolator_stencil_top
    import yfi_pkg::*;
#(
    parameter int MAX_ROW    = MAX_ROW_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    yfi_in_if.sink    i_in,
    yfi_cfg_if.sink   i_cfg,
    yfi_out_if.source o_out
);

    localparam int VW    = (VALUE_BITS > FIELD_W) ? FIELD_W : VALUE_BITS;
    localparam int PLANE = MAX_ROW * MAX_COLS;
    localparam int DEPTH = 2 * PLANE;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_COLS);
    localparam int YW    = $clog2(MAX_ROW);
    localparam int SW    = VW + 2;

    typedef logic [VW-1:0] t_val;
    typedef logic signed [SW-1:0] t_sum;

    // scan and grid
    logic [GXY_W-1:0] r_gx, r_gy;
    logic [GZ_W-1:0]  r_gz;
    logic [GXY_W:0]   r_sx, r_sy;
    logic [GZ_W:0]    r_sz;
    logic [XW-1:0]    r_wx;
    logic [YW-1:0]    r_wy;

    // reader
    logic             r_busy, r_issuing, r_cap_en, r_full;
    logic [1:0]       r_step, r_cap_step;
    logic [XW-1:0]    r_cx, r_px;
    logic [YW-1:0]    r_cy, r_py;
    logic             r_cz;
    logic [GXY_W-1:0] r_vx, r_vy;
    logic [GZ_W-1:0]  r_vz;
    t_val             r_pt [NUM_COMP][NUM_TAPS];

    // result buffer
    logic             r_hold_valid;
    logic [COMP_W-1:0] r_oc;
    t_val             r_hp [NUM_COMP][NUM_TAPS];
    logic [GXY_W-1:0] r_hx, r_hy;
    logic [GZ_W-1:0]  r_hz;

    // output register
    logic              r_ov, r_olast;
    logic [COMP_W-1:0] r_ocomp;
    logic [FIELD_W-1:0] r_omean, r_os1, r_os2, r_ocr;
    logic [GXY_W-1:0]  r_ox, r_oy;
    logic [GZ_W-1:0]   r_oz;

    logic             in_xfer, cfg_xfer, handover, complete;
    logic [GXY_W:0]   n_sx, n_sy;
    logic [GZ_W:0]    n_sz;
    logic [XW-1:0]    n_wx, wx_prev;
    logic [YW-1:0]    n_wy, wy_prev;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr [NUM_COMP];
    t_val             wdata [NUM_COMP];
    t_val             rdata [NUM_COMP];

    function automatic logic [AW-1:0] mk_addr(input logic zb, input logic [YW-1:0] y,
                                              input logic [XW-1:0] x);
        return AW'(zb) * AW'(PLANE) + AW'(y) * AW'(MAX_COLS) + AW'(x);
    endfunction

    assign in_xfer  = i_in.valid & i_in.ready;
    assign cfg_xfer = i_cfg.valid & i_cfg.ready;
    assign i_in.ready  = !r_busy;
    assign i_cfg.ready = 1'b1;
    assign complete = (r_sx >= 7'd2) && (r_sy >= 7'd2) && (r_sz >= 13'd2);
    assign handover = r_full && !r_hold_valid;

    // next scan position with wrapped store coordinates
    always_comb begin
        n_sx = r_sx + 7'd1;
        n_sy = r_sy;
        n_sz = r_sz;
        n_wx = (r_wx == XW'(MAX_COLS - 1)) ? '0 : r_wx + XW'(1);
        n_wy = r_wy;
        if (n_sx > {1'b0, r_gx} + 7'd1) begin
            n_sx = 7'd1;
            n_wx = '0;
            n_sy = r_sy + 7'd1;
            n_wy = (r_wy == YW'(MAX_ROW - 1)) ? '0 : r_wy + YW'(1);
            if (n_sy > {1'b0, r_gy} + 7'd1) begin
                n_sy = 7'd1;
                n_wy = '0;
                n_sz = r_sz + 13'd1;
                if (n_sz > {1'b0, r_gz} + 13'd1) begin
                    n_sz = 13'd1;
                end
            end
        end
        wx_prev = (r_wx == '0) ? XW'(MAX_COLS - 1) : r_wx - XW'(1);
        wy_prev = (r_wy == '0) ? YW'(MAX_ROW - 1) : r_wy - YW'(1);
    end

    assign waddr = mk_addr(r_sz[0], r_wy, r_wx);
    assign wdata[0] = i_in.e_x[VW-1:0];
    assign wdata[1] = i_in.e_y[VW-1:0];
    assign wdata[2] = i_in.e_z[VW-1:0];
    assign wdata[3] = i_in.b_x[VW-1:0];
    assign wdata[4] = i_in.b_y[VW-1:0];
    assign wdata[5] = i_in.b_z[VW-1:0];

    // one store per component, read address from the stencil point table
    for (genvar c = 0; c < NUM_COMP; c++) begin : g_store
        logic [2:0] sel;
        assign sel = point_sel(COMP_W'(c), r_step);
        assign raddr[c] = mk_addr(sel[2] ? r_cz : ~r_cz, sel[1] ? r_cy : r_py,
                                  sel[0] ? r_cx : r_px);
        yfi_field_ram #(
            .DW    (VW),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (in_xfer),
            .i_waddr (waddr),
            .i_wdata (wdata[c]),
            .i_raddr (raddr[c]),
            .o_rdata (rdata[c])
        );
    end

    // scan, config and read sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gx       <= 6'd1;
            r_gy       <= 6'd1;
            r_gz       <= 12'd1;
            r_sx       <= 7'd1;
            r_sy       <= 7'd1;
            r_sz       <= 13'd1;
            r_wx       <= '0;
            r_wy       <= '0;
            r_busy     <= 1'b0;
            r_issuing  <= 1'b0;
            r_cap_en   <= 1'b0;
            r_full     <= 1'b0;
            r_step     <= 2'd0;
            r_cap_step <= 2'd0;
        end else begin
            r_cap_en   <= r_issuing;
            r_cap_step <= r_step;
            if (r_issuing) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_issuing <= 1'b0;
                end
            end
            if (r_cap_en && r_cap_step == 2'd3) begin
                r_full <= 1'b1;
            end
            if (handover) begin
                r_full <= 1'b0;
                r_busy <= 1'b0;
            end
            if (in_xfer) begin
                r_sx <= n_sx;
                r_sy <= n_sy;
                r_sz <= n_sz;
                r_wx <= n_wx;
                r_wy <= n_wy;
                if (complete) begin
                    r_busy    <= 1'b1;
                    r_issuing <= 1'b1;
                    r_step    <= 2'd0;
                end
            end
            if (cfg_xfer) begin
                case (i_cfg.reg_index)
                    REG_GRID_X: r_gx <= i_cfg.wdata[GXY_W-1:0];
                    REG_GRID_Y: r_gy <= i_cfg.wdata[GXY_W-1:0];
                    REG_GRID_Z: r_gz <= i_cfg.wdata;
                    default: ;
                endcase
                if (i_cfg.reg_index == REG_GRID_X || i_cfg.reg_index == REG_GRID_Y ||
                    i_cfg.reg_index == REG_GRID_Z) begin
                    r_sx <= 7'd1;
                    r_sy <= 7'd1;
                    r_sz <= 13'd1;
                    r_wx <= '0;
                    r_wy <= '0;
                end
            end
        end
    end

    // stencil coordinates and captured points
    always_ff @(posedge i_clk) begin
        if (in_xfer && complete) begin
            r_cx <= r_wx;
            r_px <= wx_prev;
            r_cy <= r_wy;
            r_py <= wy_prev;
            r_cz <= r_sz[0];
            r_vx <= GXY_W'(r_sx - 7'd1);
            r_vy <= GXY_W'(r_sy - 7'd1);
            r_vz <= GZ_W'(r_sz - 13'd1);
        end
        if (r_cap_en) begin
            for (int c = 0; c < NUM_COMP; c++) begin
                r_pt[c][r_cap_step] <= rdata[c];
            end
        end
        if (handover) begin
            r_hp <= r_pt;
            r_hx <= r_vx;
            r_hy <= r_vy;
            r_hz <= r_vz;
        end
    end

    // coefficients of the component at the head of the result buffer
    t_sum w0, w1, w2, w3;
    t_sum s_mean, s_s1, s_s2, s_cr;
    t_val c_mean, c_s1, c_s2, c_cr;

    always_comb begin
        w0 = SW'(signed'(r_hp[r_oc][0]));
        w1 = SW'(signed'(r_hp[r_oc][1]));
        w2 = SW'(signed'(r_hp[r_oc][2]));
        w3 = SW'(signed'(r_hp[r_oc][3]));
        if (r_oc == COMP_BX || r_oc == COMP_BY || r_oc == COMP_BZ) begin
            s_mean = (w1 + w0) >>> 1;
            s_s1   = (w1 - w0) >>> 1;
            s_s2   = '0;
            s_cr   = '0;
        end else begin
            s_mean = ((w3 + w0) + (w1 + w2)) >>> 2;
            s_s1   = ((w3 - w0) + (w1 - w2)) >>> 2;
            s_s2   = ((w3 - w0) - (w1 - w2)) >>> 2;
            s_cr   = ((w3 + w0) - (w1 + w2)) >>> 2;
        end
        c_mean = s_mean[VW-1:0];
        c_s1   = s_s1[VW-1:0];
        c_s2   = s_s2[VW-1:0];
        c_cr   = s_cr[VW-1:0];
    end

    // result buffer drain into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov         <= 1'b0;
            r_hold_valid <= 1'b0;
            r_oc         <= COMP_EX;
        end else begin
            if (handover) begin
                r_hold_valid <= 1'b1;
                r_oc         <= COMP_EX;
            end
            if (o_out.ready || !r_ov) begin
                r_ov <= r_hold_valid;
                if (r_hold_valid) begin
                    r_ocomp <= r_oc;
                    r_omean <= FIELD_W'(c_mean);
                    r_os1   <= FIELD_W'(c_s1);
                    r_os2   <= FIELD_W'(c_s2);
                    r_ocr   <= FIELD_W'(c_cr);
                    r_ox    <= r_hx;
                    r_oy    <= r_hy;
                    r_oz    <= r_hz;
                    r_olast <= (r_oc == COMP_BZ);
                    r_oc    <= r_oc + 3'd1;
                    if (r_oc == COMP_BZ) begin
                        r_hold_valid <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.component    = r_ocomp;
    assign o_out.mean_value   = r_omean;
    assign o_out.slope_first  = r_os1;
    assign o_out.slope_second = r_os2;
    assign o_out.cross_term   = r_ocr;
    assign o_out.voxel_x      = r_ox;
    assign o_out.voxel_y      = r_oy;
    assign o_out.voxel_z      = r_oz;
    assign o_out.last         = r_olast;

    // a full capture set moves into an empty result buffer starting at ex
    a_handover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full && !r_hold_valid |=> r_hold_valid && r_oc == COMP_EX && !r_full)
        else $error("capture handover failed");

    // last marks exactly the bz result
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_olast == (r_ocomp == COMP_BZ)))
        else $error("last flag out of place");

    // reads are issued only for a voxel that holds the reader
    a_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_issuing || r_cap_en || r_full) |-> r_busy)
        else $error("stencil read outside busy window");

    // no new voxel can overwrite stores while its stencil is being read
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issuing |-> !i_in.ready)
        else $error("input accepted during stencil read");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import yfi_pkg::*;

    typedef struct {
        logic signed [FIELD_W-1:0] fld [NUM_COMP];
    } t_voxel;

    typedef struct {
        logic [COMP_W-1:0]         component;
        logic signed [FIELD_W-1:0] mean_value;
        logic signed [FIELD_W-1:0] slope_first;
        logic signed [FIELD_W-1:0] slope_second;
        logic signed [FIELD_W-1:0] cross_term;
        logic [GXY_W-1:0]          voxel_x;
        logic [GXY_W-1:0]          voxel_y;
        logic [GZ_W-1:0]           voxel_z;
        logic                      last;
    } t_coef;

    localparam int PLANE = MAX_ROW_DEF * MAX_COLS_DEF;
    localparam int MEM_WORDS = 2 * PLANE;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT = 5000;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    logic i_clk;
    logic i_rst_n;

    yfi_in_if  in_if ();
    yfi_cfg_if cfg_if ();
    yfi_out_if out_if ();

    yee_field_interpolator_stencil_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // predictor state: grid size, scan position, two planes of each field
    logic [GXY_W-1:0] gx, gy;
    logic [GZ_W-1:0]  gz;
    int unsigned      px, py, pz;
    logic signed [FIELD_W-1:0] plane_mem [NUM_COMP][MEM_WORDS];

    t_voxel voxel_q [$];
    t_coef  coef_q [$];
    int     fail_cnt;
    int     coef_seen;
    int     voxels_sent;
    int     idle_cnt;
    bit     quiet;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int unsigned mem_addr(int unsigned x, int unsigned y,
                                             int unsigned z);
        return ((z & 1) * PLANE + ((y - 1) % MAX_ROW_DEF) * MAX_COLS_DEF
                + ((x - 1) % MAX_COLS_DEF)) % MEM_WORDS;
    endfunction

    function automatic t_coef make_coef(int c, longint m, longint s1, longint s2,
                                        longint cr, int unsigned x, int unsigned y,
                                        int unsigned z);
        t_coef r;
        r.component    = COMP_W'(c);
        r.mean_value   = FIELD_W'(m);
        r.slope_first  = FIELD_W'(s1);
        r.slope_second = FIELD_W'(s2);
        r.cross_term   = FIELD_W'(cr);
        r.voxel_x      = GXY_W'(x);
        r.voxel_y      = GXY_W'(y);
        r.voxel_z      = GZ_W'(z);
        r.last         = (c == COMP_BZ);
        return r;
    endfunction

    // store one voxel and queue the six coefficient sets it completes
    task automatic interpolate(input t_voxel v);
        int unsigned x, y, z;
        int unsigned a0, ax, ay, az, ayz, azx, axy;
        longint w0, w1, w2, w3;
        int unsigned taps [3][4];
        for (int c = 0; c < NUM_COMP; c++)
            plane_mem[c][mem_addr(px, py, pz)] = v.fld[c];
        if (px >= 2 && py >= 2 && pz >= 2) begin
            x = px - 1; y = py - 1; z = pz - 1;
            a0  = mem_addr(x, y, z);   ax  = mem_addr(px, y, z);
            ay  = mem_addr(x, py, z);  az  = mem_addr(x, y, pz);
            ayz = mem_addr(x, py, pz); azx = mem_addr(px, y, pz);
            axy = mem_addr(px, py, z);
            taps[0] = '{a0, ay, az, ayz};
            taps[1] = '{a0, az, ax, azx};
            taps[2] = '{a0, ax, ay, axy};
            for (int c = COMP_EX; c <= COMP_EZ; c++) begin
                w0 = plane_mem[c][taps[c][0]]; w1 = plane_mem[c][taps[c][1]];
                w2 = plane_mem[c][taps[c][2]]; w3 = plane_mem[c][taps[c][3]];
                coef_q.push_back(make_coef(c, ((w3 + w0) + (w1 + w2)) >>> 2,
                    ((w3 - w0) + (w1 - w2)) >>> 2, ((w3 - w0) - (w1 - w2)) >>> 2,
                    ((w3 + w0) - (w1 + w2)) >>> 2, x, y, z));
            end
            // B components: pair along own axis, halved
            w0 = plane_mem[COMP_BX][a0]; w1 = plane_mem[COMP_BX][ax];
            coef_q.push_back(make_coef(COMP_BX, (w1 + w0) >>> 1, (w1 - w0) >>> 1,
                                       0, 0, x, y, z));
            w0 = plane_mem[COMP_BY][a0]; w1 = plane_mem[COMP_BY][ay];
            coef_q.push_back(make_coef(COMP_BY, (w1 + w0) >>> 1, (w1 - w0) >>> 1,
                                       0, 0, x, y, z));
            w0 = plane_mem[COMP_BZ][a0]; w1 = plane_mem[COMP_BZ][az];
            coef_q.push_back(make_coef(COMP_BZ, (w1 + w0) >>> 1, (w1 - w0) >>> 1,
                                       0, 0, x, y, z));
        end
        // raster advance, x fastest
        px++;
        if (px > gx + 1) begin
            px = 1; py++;
            if (py > gy + 1) begin
                py = 1; pz++;
                if (pz > gz + 1) pz = 1;
            end
        end
    endtask

    function automatic logic signed [FIELD_W-1:0] pick_value(int mode);
        case (mode)
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return FIELD_W'($signed($urandom_range(0, 400)) - 200);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_voxels(input int n, input int mode);
        t_voxel v;
        for (int i = 0; i < n; i++) begin
            for (int c = 0; c < NUM_COMP; c++)
                v.fld[c] = pick_value(mode < 0 ? $urandom_range(0, 7) : (mode + c) % 5);
            voxel_q.push_back(v);
        end
    endtask

    // register write on the config channel; predictor follows at the transfer
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wdata     <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_GRID_X: gx = val[GXY_W-1:0];
            REG_GRID_Y: gy = val[GXY_W-1:0];
            REG_GRID_Z: gz = val[GZ_W-1:0];
            default: ;
        endcase
        if (idx == REG_GRID_X || idx == REG_GRID_Y || idx == REG_GRID_Z) begin
            px = 1; py = 1; pz = 1;
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (voxel_q.size() != 0 || in_if.valid || coef_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [CFG_DATA_W-1:0] x,
                            input logic [CFG_DATA_W-1:0] y,
                            input logic [CFG_DATA_W-1:0] z);
        write_reg(REG_GRID_X, x);
        write_reg(REG_GRID_Y, y);
        write_reg(REG_GRID_Z, z);
    endtask

    // voxel driver: pops pending voxels, idles in random bursts
    int unsigned in_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                t_voxel v;
                v.fld = '{in_if.e_x, in_if.e_y, in_if.e_z,
                          in_if.b_x, in_if.b_y, in_if.b_z};
                interpolate(v);
                voxels_sent++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_if.valid <= 1'b0;
                end else if (voxel_q.size() != 0) begin
                    t_voxel v;
                    v = voxel_q.pop_front();
                    in_if.e_x <= v.fld[0]; in_if.e_y <= v.fld[1];
                    in_if.e_z <= v.fld[2]; in_if.b_x <= v.fld[3];
                    in_if.b_y <= v.fld[4]; in_if.b_z <= v.fld[5];
                    in_if.valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        in_gap = $urandom_range(1, 16);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compare each transfer with the oldest expectation
    int unsigned out_hold;
    bit          long_hold_done;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            out_hold = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                coef_seen++;
                if (coef_q.size() == 0) begin
                    $error("unexpected result transfer, component %0d", out_if.component);
                    fail_cnt++;
                end else begin
                    t_coef e;
                    e = coef_q.pop_front();
                    if (out_if.component !== e.component) begin
                        $error("component exp %0d got %0d", e.component, out_if.component);
                        fail_cnt++;
                    end
                    if (out_if.mean_value !== e.mean_value) begin
                        $error("mean_value exp %0d got %0d", e.mean_value, out_if.mean_value);
                        fail_cnt++;
                    end
                    if (out_if.slope_first !== e.slope_first) begin
                        $error("slope_first exp %0d got %0d", e.slope_first,
                               out_if.slope_first);
                        fail_cnt++;
                    end
                    if (out_if.slope_second !== e.slope_second) begin
                        $error("slope_second exp %0d got %0d", e.slope_second,
                               out_if.slope_second);
                        fail_cnt++;
                    end
                    if (out_if.cross_term !== e.cross_term) begin
                        $error("cross_term exp %0d got %0d", e.cross_term, out_if.cross_term);
                        fail_cnt++;
                    end
                    if (out_if.voxel_x !== e.voxel_x) begin
                        $error("voxel_x exp %0d got %0d", e.voxel_x, out_if.voxel_x);
                        fail_cnt++;
                    end
                    if (out_if.voxel_y !== e.voxel_y) begin
                        $error("voxel_y exp %0d got %0d", e.voxel_y, out_if.voxel_y);
                        fail_cnt++;
                    end
                    if (out_if.voxel_z !== e.voxel_z) begin
                        $error("voxel_z exp %0d got %0d", e.voxel_z, out_if.voxel_z);
                        fail_cnt++;
                    end
                    if (out_if.last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, out_if.last);
                        fail_cnt++;
                    end
                end
            end
            // one long hold so the input side backs up and stalls
            if (!long_hold_done && coef_seen >= 60) begin
                long_hold_done = 1;
                out_hold = 400;
            end
            if (out_hold > 0) begin
                out_hold--;
                out_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                out_hold = $urandom_range(1, 16) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            idle_cnt = 0;
        end else begin
            idle_cnt++;
            if (idle_cnt >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        in_if.valid = 1'b0;
        in_if.e_x = '0; in_if.e_y = '0; in_if.e_z = '0;
        in_if.b_x = '0; in_if.b_y = '0; in_if.b_z = '0;
        cfg_if.valid = 1'b0;
        cfg_if.reg_index = '0;
        cfg_if.wdata = '0;
        out_if.ready = 1'b0;
        gx = 1; gy = 1; gz = 1;
        px = 1; py = 1; pz = 1;
        fail_cnt = 0; coef_seen = 0; voxels_sent = 0; idle_cnt = 0;
        quiet = 0; long_hold_done = 0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset grid, field extremes, wrap at end of scan
        for (int m = 0; m < 5; m++) queue_voxels(3, m);
        queue_voxels(1, -1);
        wait_idle();

        // unknown index is ignored and keeps the scan position
        write_reg(REG_NONE, 12'hfff);
        queue_voxels(8, -1);
        wait_idle();

        // widest x, upper data bits beyond the register width
        set_grid(12'hfff, 12'd1, 12'd1);
        queue_voxels(200, -1);
        wait_idle();

        set_grid(12'd3, 12'd2, 12'd4);
        queue_voxels(60, -1);
        wait_idle();

        // zero size on one axis: voxels stored, nothing emitted
        set_grid(12'd0, 12'd5, 12'd3);
        queue_voxels(20, -1);
        wait_idle();

        // deepest z, partial scan only
        set_grid(12'd2, 12'd3, 12'hfff);
        queue_voxels(36, -1);
        wait_idle();

        set_grid(12'd2, 12'd2, 12'd0);
        queue_voxels(12, -1);
        wait_idle();

        write_reg(REG_GRID_Y, 12'd63);
        write_reg(REG_GRID_X, 12'd1);
        write_reg(REG_GRID_Z, 12'd1);
        queue_voxels(20, -1);
        wait_idle();

        // last part without idling on either side
        quiet = 1;
        set_grid(12'd5, 12'd4, 12'd2);
        queue_voxels(60, -1);
        wait_idle();

        $display("covered %0d voxels, %0d coefficient transfers, grids from zero to max",
                 voxels_sent, coef_seen);
        $display("with stalls, idle bursts and a long output hold");
        if (fail_cnt == 0 && coef_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
